@@ sv/ordered_value_list_engine_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ORDERED_VALUE_LIST_ENGINE_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define OVLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define OVLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ovle_pkg.sv @@
`default_nettype none

package ovle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_COUNT   = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_REPLACE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ sv/ovle_ram.sv @@
`default_nettype none

module ovle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/ordered_value_list_engine.sv @@
// Ordered list of signed 32-bit values held in a 64-entry single-port-write RAM.
// One request transaction is taken at a time and gives one response transaction.
// Append writes the tail entry on acceptance and goes straight to the response. Count, delete and
// replace walk the stored entries through the RAM read port, one entry per
// cycle, with one shared 32-bit equality compare; an empty list skips the walk.
// Delete compacts in place through the same RAM write port while the walk
// runs. The request side is stalled while an action is in progress; a
// finished response sits in an output register, and a new request can be
// taken while it waits.
`default_nettype none
`include "ordered_value_list_engine_macros.svh"

module ordered_value_list_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire ovle_pkg::action_t                 action,
  input  wire logic signed [ovle_pkg::VAL_W-1:0] value,
  input  wire logic signed [ovle_pkg::VAL_W-1:0] new_value,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic             [ovle_pkg::CNT_W-1:0] match_count,
  output logic             [ovle_pkg::CNT_W-1:0] list_length,
  output logic                                   status
);

  ovle_pkg::state_t  st;
  ovle_pkg::action_t act;
  logic [ovle_pkg::VAL_W-1:0] key;
  logic [ovle_pkg::VAL_W-1:0] repl;
  logic [ovle_pkg::CNT_W-1:0] length;
  logic [ovle_pkg::CNT_W-1:0] rd_idx;
  logic [ovle_pkg::CNT_W-1:0] hits;
  logic [ovle_pkg::CNT_W-1:0] kept;
  logic [ovle_pkg::IDX_W-1:0] p_idx;
  logic                       p_valid;
  logic                       full_drop;

  logic                       req_take;
  logic                       full;
  logic                       issue;
  logic                       eq;
  logic                       ram_we;
  logic [ovle_pkg::IDX_W-1:0] ram_waddr;
  logic [ovle_pkg::VAL_W-1:0] ram_wdata;
  logic [ovle_pkg::VAL_W-1:0] rd_data;

  assign req_stall = (st != ovle_pkg::ST_IDLE);
  assign req_take  = req_valid && (st == ovle_pkg::ST_IDLE);
  assign full      = (length == ovle_pkg::CNT_W'(ovle_pkg::CAPACITY));
  assign issue     = (st == ovle_pkg::ST_RUN) && (rd_idx != length);
  assign eq        = (rd_data == key);

  // Write port: tail on append, compaction slot on delete, in place on replace.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_idx;
    ram_wdata = repl;
    if (st == ovle_pkg::ST_IDLE) begin
      ram_we    = req_take && (action == ovle_pkg::ACT_APPEND) && !full;
      ram_waddr = length[ovle_pkg::IDX_W-1:0];
      ram_wdata = value;
    end else if (act == ovle_pkg::ACT_DELETE) begin
      ram_we    = p_valid && !eq;
      ram_waddr = kept[ovle_pkg::IDX_W-1:0];
      ram_wdata = rd_data;
    end else if (act == ovle_pkg::ACT_REPLACE) begin
      ram_we    = p_valid && eq;
    end
  end

  ovle_ram #(
    .WIDTH(ovle_pkg::VAL_W),
    .DEPTH(ovle_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(rd_idx[ovle_pkg::IDX_W-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ovle_pkg::ST_IDLE;
      length    <= '0;
      rd_idx    <= '0;
      p_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      p_valid <= issue;
      p_idx   <= rd_idx[ovle_pkg::IDX_W-1:0];
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rsp_valid && !rsp_stall && (st != ovle_pkg::ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        ovle_pkg::ST_IDLE: begin
          if (req_take) begin
            act       <= action;
            key       <= value;
            repl      <= new_value;
            rd_idx    <= '0;
            hits      <= '0;
            kept      <= '0;
            full_drop <= 1'b0;
            if (action == ovle_pkg::ACT_APPEND) begin
              if (full) begin
                full_drop <= 1'b1;
              end else begin
                length <= length + 1'b1;
              end
              st <= ovle_pkg::ST_DONE;
            end else if (length == '0) begin
              st <= ovle_pkg::ST_DONE;
            end else begin
              st <= ovle_pkg::ST_RUN;
            end
          end
        end
        ovle_pkg::ST_RUN: begin
          if (p_valid && eq) begin
            hits <= hits + 1'b1;
          end
          if (p_valid && !eq) begin
            kept <= kept + 1'b1;
          end
          // last read has been compared; kept is final here
          if (!issue && !p_valid) begin
            if (act == ovle_pkg::ACT_DELETE) begin
              length <= kept;
            end
            st <= ovle_pkg::ST_DONE;
          end
        end
        ovle_pkg::ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            match_count <= hits;
            list_length <= length;
            status      <= full_drop;
            st          <= ovle_pkg::ST_IDLE;
          end
        end
        default: begin
          st <= ovle_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `OVLE_ASSERT_NOW(a_run_nonempty, st == ovle_pkg::ST_RUN, length != '0,
    "walk running on an empty list")
  `OVLE_ASSERT_NOW(a_compact_behind, p_valid && act == ovle_pkg::ACT_DELETE,
    kept <= ovle_pkg::CNT_W'(p_idx), "compaction slot ahead of read slot")
  `OVLE_ASSERT_NEXT(a_full_append_holds,
    req_take && action == ovle_pkg::ACT_APPEND && full,
    $stable(length) && full_drop, "append on full list changed the length")
  `OVLE_ASSERT_NOW(a_done_drained, st == ovle_pkg::ST_DONE, !p_valid && !issue,
    "response built with a read still in flight")

endmodule

`default_nettype wire
